// ===== hdl/abkd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abkd_pkg
// Shared types and constants of the analog keypad event decoder: field
// widths, event kinds, column windows and the 4x4 key code table.
// ----------------------------------------------------------------------------
package abkd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int ROW_W      = 2;
  localparam int KEY_ROWS   = 4;
  localparam int KEY_COLS   = 4;
  localparam int COL_W      = 3;
  localparam int CODE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_W    = 16;

  // Column code held per row; columns 0..3 are keys.
  localparam logic [COL_W-1:0] NO_KEY = 3'd7;

  typedef enum logic [KIND_W-1:0] {
    EV_KEY_DOWN    = 2'd0,
    EV_KEY_UP      = 2'd1,
    EV_KEY_PRESSED = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
  } window_t;

  typedef logic [CODE_W-1:0] key_code_t;

  // Indexed by {row, column}.
  localparam key_code_t KEY_TABLE [KEY_ROWS*KEY_COLS] = '{
    "1", "2", "3", "A",
    "4", "5", "6", "B",
    "7", "8", "9", "C",
    "*", "0", "#", "D"
  };

endpackage
`default_nettype wire

// ===== hdl/abkd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abkd_cfg_regs
// APB register file holding the inclusive sample window of each column.
// Register 2*c is the low bound of column c, register 2*c+1 its high bound.
// ----------------------------------------------------------------------------
module abkd_cfg_regs
  import abkd_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]         cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]         cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]         cfg_prdata,
  output logic                               cfg_pready,
  output window_t   [KEY_COLS-1:0]           windows
);

  window_t [KEY_COLS-1:0] win_r;
  logic                   wr_en;
  logic [1:0]             reg_col;
  logic                   reg_is_high;

  assign cfg_pready  = 1'b1;
  assign wr_en       = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_col     = cfg_paddr[4:3];
  assign reg_is_high = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < KEY_COLS; c++) begin
        win_r[c].low  <= '1;
        win_r[c].high <= '0;
      end
    end else if (wr_en) begin
      if (reg_is_high) begin
        win_r[reg_col].high <= cfg_pwdata[SAMPLE_W-1:0];
      end else begin
        win_r[reg_col].low <= cfg_pwdata[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_is_high) begin
      cfg_prdata[SAMPLE_W-1:0] = win_r[reg_col].high;
    end else begin
      cfg_prdata[SAMPLE_W-1:0] = win_r[reg_col].low;
    end
  end

  assign windows = win_r;

endmodule
`default_nettype wire

// ===== hdl/abkd_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abkd_classify
// Maps one sample to a column by checking the column windows in priority
// order; the lowest matching column wins, no match gives NO_KEY.
// ----------------------------------------------------------------------------
module abkd_classify
  import abkd_pkg::*;
(
  input  wire window_t [KEY_COLS-1:0] windows,
  input  wire logic    [SAMPLE_W-1:0] sample,
  output logic         [COL_W-1:0]    column
);

  always_comb begin
    column = NO_KEY;
    // Scan from the top so the lowest column overrides.
    for (int c = KEY_COLS - 1; c >= 0; c--) begin
      if ((windows[c].low <= sample) && (sample <= windows[c].high)) begin
        column = COL_W'(c);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/analog_keypad_event_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// analog_keypad_event_decoder
// Classifies analog row readings into keypad columns and emits key events.
// ----------------------------------------------------------------------------
// Each input item is one 10-bit reading (in_tdata[9:0]) of the row named by
// in_tuser. An accepted item waits in the input register and its event
// moves into the output register once that register is free. A new item
// is taken every cycle while items cause at most one event and the output
// is not stalled; a key release causes two events (key up, then key
// pressed) and holds the output register until both have left, so a later
// item that causes an event waits for them. Each event carries its kind
// on out_tuser and the key code on out_tdata. Rows at or above ROW_COUNT
// are dropped without events. The column windows are
// programmed over the APB port and should only be changed while the block is
// idle.
// ----------------------------------------------------------------------------
module analog_keypad_event_decoder
  import abkd_pkg::*;
#(
  parameter int ROW_COUNT = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [TDATA_W-1:0]    in_tdata,   // [9:0] sample
  input  wire logic [ROW_W-1:0]      in_tuser,   // [1:0] row_index
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [CODE_W-1:0]     out_tdata,  // [7:0] key_code
  output logic      [KIND_W-1:0]     out_tuser,  // [1:0] event_kind
  output logic                       out_tlast,  // last_of_run
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // Rows beyond the key table never match.
  localparam int ROWS_USED = (ROW_COUNT < KEY_ROWS) ? ROW_COUNT : KEY_ROWS;

  window_t [KEY_COLS-1:0] windows;

  logic                in_vld_r;
  logic [ROW_W-1:0]    in_row_r;
  logic [SAMPLE_W-1:0] in_sample_r;

  logic [COL_W-1:0]    col_r [ROWS_USED];
  logic [COL_W-1:0]    col_nxt;
  logic [COL_W-1:0]    last_col;
  logic                row_ok;
  logic                changed;
  logic                is_down;
  logic                is_release;
  logic                emit;
  logic                out_free;
  logic                adv;
  key_code_t           code_nxt;

  event_kind_t         kind_r;
  key_code_t           code_r;
  logic                last_r;
  logic                out_vld_r;
  logic                pend_r;

  abkd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .windows     (windows)
  );

  abkd_classify u_classify (
    .windows (windows),
    .sample  (in_sample_r),
    .column  (col_nxt)
  );

  // Stored column of the row in the input register.
  always_comb begin
    last_col = NO_KEY;
    row_ok   = 1'b0;
    for (int i = 0; i < ROWS_USED; i++) begin
      if (in_row_r == ROW_W'(i)) begin
        last_col = col_r[i];
        row_ok   = 1'b1;
      end
    end
  end

  assign changed    = row_ok && (last_col != col_nxt);
  assign is_down    = changed && (col_nxt != NO_KEY);
  assign is_release = changed && (col_nxt == NO_KEY) && (last_col != NO_KEY);
  assign emit       = is_down || is_release;

  assign code_nxt = is_down ? KEY_TABLE[{in_row_r, col_nxt[1:0]}]
                            : KEY_TABLE[{in_row_r, last_col[1:0]}];

  // Output register is free when empty or its last event leaves this cycle.
  assign out_free  = !out_vld_r || (out_tready && !pend_r);
  assign adv       = in_vld_r && (!emit || out_free);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_row_r    <= in_tuser;
      in_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS_USED; i++) begin
        col_r[i] <= NO_KEY;
      end
    end else if (adv) begin
      for (int i = 0; i < ROWS_USED; i++) begin
        if (in_row_r == ROW_W'(i)) begin
          col_r[i] <= col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else if (adv && emit) begin
      out_vld_r <= 1'b1;
      pend_r    <= is_release;
    end else if (out_vld_r && out_tready) begin
      // Hold for the key pressed event that follows a key up.
      out_vld_r <= pend_r;
      pend_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      kind_r <= is_down ? EV_KEY_DOWN : EV_KEY_UP;
      code_r <= code_nxt;
      last_r <= is_down;
    end else if (out_vld_r && out_tready && pend_r) begin
      kind_r <= EV_KEY_PRESSED;
      last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = code_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

// ===== hdl/abkd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abkd_checker
// Port-level checks of the keypad event decoder's result stream, bound to
// the top level.
// ----------------------------------------------------------------------------
module abkd_checker
  import abkd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [CODE_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0] out_tuser,
  input wire logic              out_tlast
);

  logic [KIND_W-1:0] kind;
  key_code_t         code;

  assign kind = out_tuser;
  assign code = out_tdata;

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (kind == EV_KEY_DOWN) || (kind == EV_KEY_UP) || (kind == EV_KEY_PRESSED))
    else $error("unknown event kind");

  // Only a key up opens a two-event run.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((kind == EV_KEY_UP) == !out_tlast))
    else $error("last_of_run does not match event kind");

  // Key up is followed at once by key pressed for the same key.
  a_up_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (kind == EV_KEY_UP)
    |=> out_tvalid && (kind == EV_KEY_PRESSED) && (code == $past(code)) && out_tlast)
    else $error("key up not followed by key pressed for the same key");

endmodule

bind analog_keypad_event_decoder abkd_checker u_abkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== test/tb_analog_keypad_event_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_analog_keypad_event_decoder
// Self-checking bench for the analog keypad event decoder. It feeds row
// readings over the input stream under several column window settings and
// predicts key down, key up and key pressed events. Every event that leaves
// the block is compared with the oldest predicted one, with random idling on
// both stream sides in all but the last run.
// ----------------------------------------------------------------------------
module tb_analog_keypad_event_decoder;
  import abkd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 10;

  // Register indexes of the column windows.
  localparam int REG_C0_LOW  = 0;
  localparam int REG_C0_HIGH = 1;
  localparam int REG_C1_LOW  = 2;
  localparam int REG_C1_HIGH = 3;
  localparam int REG_C2_LOW  = 4;
  localparam int REG_C2_HIGH = 5;
  localparam int REG_C3_LOW  = 6;
  localparam int REG_C3_HIGH = 7;
  localparam int REG_LOW_OF [KEY_COLS]  = '{REG_C0_LOW, REG_C1_LOW, REG_C2_LOW, REG_C3_LOW};
  localparam int REG_HIGH_OF [KEY_COLS] = '{REG_C0_HIGH, REG_C1_HIGH, REG_C2_HIGH, REG_C3_HIGH};

  localparam logic [CODE_W-1:0] KEY_CHARS [KEY_ROWS*KEY_COLS] = '{
    "1", "2", "3", "A",
    "4", "5", "6", "B",
    "7", "8", "9", "C",
    "*", "0", "#", "D"
  };

  typedef struct {
    logic [ROW_W-1:0]    row;
    logic [SAMPLE_W-1:0] sample;
  } reading_t;

  typedef struct {
    event_kind_t kind;
    key_code_t   code;
    logic        last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;   // [9:0] sample
  logic [ROW_W-1:0] in_tuser = '0;     // [1:0] row_index
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [CODE_W-1:0] out_tdata;        // [7:0] key_code
  logic [KIND_W-1:0] out_tuser;        // [1:0] event_kind
  logic out_tlast;                     // last_of_run
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  reading_t reading_q[$];
  key_event_t key_event_q[$];

  logic [SAMPLE_W-1:0] win_low [KEY_COLS];
  logic [SAMPLE_W-1:0] win_high [KEY_COLS];
  logic [COL_W-1:0] held_column [KEY_ROWS];

  logic in_fire = 1'b0;
  int send_idle = 0;
  int recv_idle = 0;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int fail_count = 0;

  analog_keypad_event_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Lowest-numbered matching window wins.
  function automatic logic [COL_W-1:0] column_of(input logic [SAMPLE_W-1:0] sample);
    for (int c = 0; c < KEY_COLS; c++) begin
      if (win_low[c] <= sample && sample <= win_high[c]) begin
        return COL_W'(c);
      end
    end
    return NO_KEY;
  endfunction

  task automatic predict_reading(input logic [ROW_W-1:0] row, input logic [SAMPLE_W-1:0] sample);
    logic [COL_W-1:0] prev;
    logic [COL_W-1:0] next;
    key_code_t code;
    begin
      prev = held_column[row];
      next = column_of(sample);
      held_column[row] = next;
      if (prev != next) begin
        if (next != NO_KEY) begin
          code = KEY_CHARS[row * KEY_COLS + next[1:0]];
          key_event_q.push_back('{EV_KEY_DOWN, code, 1'b1});
        end else begin
          code = KEY_CHARS[row * KEY_COLS + prev[1:0]];
          key_event_q.push_back('{EV_KEY_UP, code, 1'b0});
          key_event_q.push_back('{EV_KEY_PRESSED, code, 1'b1});
        end
      end
    end
  endtask

  task automatic check_key_event();
    key_event_t want;
    begin
      if (key_event_q.size() == 0) begin
        $error("unexpected key event: event_kind %0d key_code %h last_of_run %b",
               out_tuser, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = key_event_q.pop_front();
        if (out_tuser !== want.kind) begin
          $error("event_kind mismatch: expected %0d, got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata !== want.code) begin
          $error("key_code mismatch: expected %h, got %h", want.code, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run mismatch: expected %b, got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      in_fire <= rst_n && in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready) begin
        predict_reading(in_tuser, in_tdata[SAMPLE_W-1:0]);
      end
      if (rst_n && out_tvalid && out_tready) begin
        check_key_event();
      end
    end
  end

  // Sender: hold an item until taken, then idle in bursts or load the next one.
  always @(negedge clk) begin
    reading_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (send_idle != 0 && $urandom_range(1, send_idle) == 1) begin
      in_tvalid <= 1'b0;
      send_gap = $urandom_range(0, 18);
    end else if (reading_q.size() != 0) begin
      r = reading_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= r.row;
      in_tdata <= {{(TDATA_W-SAMPLE_W){1'b0}}, r.sample};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: stall in bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (recv_idle != 0 && $urandom_range(1, recv_idle) == 1) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Called at a falling edge while the block is idle.
  task automatic write_reg(input int idx, input logic [SAMPLE_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    begin
      word = $urandom;
      word[SAMPLE_W-1:0] = value;
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b1;
      cfg_paddr <= CFG_ADDR_W'(4 * idx);
      cfg_pwdata <= word;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(negedge clk);
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      if (idx % 2 == 0) win_low[idx / 2] = value;
      else win_high[idx / 2] = value;
      @(negedge clk);
    end
  endtask

  task automatic set_window(input int col, input int lo, input int hi);
    begin
      write_reg(REG_LOW_OF[col], SAMPLE_W'(lo));
      write_reg(REG_HIGH_OF[col], SAMPLE_W'(hi));
    end
  endtask

  task automatic set_ladder();
    begin
      set_window(0, 0, 99);
      set_window(1, 150, 299);
      set_window(2, 350, 549);
      set_window(3, 600, 849);
    end
  endtask

  // Wait for every result, then let items that cause none drain out.
  task automatic wait_idle();
    begin
      do @(negedge clk);
      while (reading_q.size() != 0 || in_tvalid || key_event_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end
  endtask

  task automatic add_reading(input int row, input int sample);
    reading_q.push_back('{ROW_W'(row), SAMPLE_W'(sample)});
  endtask

  function automatic logic [SAMPLE_W-1:0] key_sample(input int col);
    int lo;
    int hi;
    begin
      lo = win_low[col];
      hi = win_high[col];
      case ($urandom_range(0, 5))
        0: return SAMPLE_W'(lo);
        1: return SAMPLE_W'(hi);
        2: return SAMPLE_W'(lo - 1);
        3: return SAMPLE_W'(hi + 1);
        default: begin
          if (lo <= hi) return SAMPLE_W'($urandom_range(lo, hi));
          return SAMPLE_W'($urandom);
        end
      endcase
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] release_sample();
    logic [SAMPLE_W-1:0] s;
    begin
      s = SAMPLE_W'($urandom);
      for (int k = 0; k < 24 && column_of(s) != NO_KEY; k++) s = SAMPLE_W'($urandom);
      return s;
    end
  endfunction

  // Press runs: hold a key, maybe slide to another, usually release; some noise.
  task automatic run_random(input int count, input bit with_idle);
    int row;
    int col;
    int queued;
    int batch_end;
    begin
      queued = 0;
      while (queued < count) begin
        @(posedge clk);
        send_idle = with_idle ? 3 * $urandom_range(0, 3) : 0;
        recv_idle = with_idle ? 3 * $urandom_range(0, 3) : 0;
        batch_end = queued + 40;
        while (queued < batch_end && queued < count) begin
          row = $urandom_range(0, KEY_ROWS - 1);
          if ($urandom_range(0, 9) == 0) begin
            add_reading(row, $urandom_range(0, 1023));
            queued++;
          end else begin
            col = $urandom_range(0, KEY_COLS - 1);
            repeat ($urandom_range(1, 3)) begin
              add_reading(row, key_sample(col));
              queued++;
            end
            if ($urandom_range(0, 3) == 0) begin
              add_reading(row, key_sample($urandom_range(0, KEY_COLS - 1)));
              queued++;
            end
            if ($urandom_range(0, 9) < 7) begin
              repeat ($urandom_range(1, 2)) begin
                add_reading(row, release_sample());
                queued++;
              end
            end
          end
        end
        while (reading_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    for (int c = 0; c < KEY_COLS; c++) begin
      win_low[c] = '1;
      win_high[c] = '0;
    end
    for (int r = 0; r < KEY_ROWS; r++) held_column[r] = NO_KEY;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Windows at reset match nothing.
    @(posedge clk);
    add_reading(0, 0);
    add_reading(3, 1023);
    add_reading(1, 512);
    wait_idle();

    set_ladder();
    @(posedge clk);
    add_reading(0, 0);      // press
    add_reading(0, 0);      // held, no event
    add_reading(0, 1023);   // release: up then pressed
    add_reading(1, 150);
    add_reading(1, 299);
    add_reading(1, 600);    // slide to another key
    add_reading(1, 849);
    add_reading(1, 850);
    add_reading(2, 350);
    add_reading(2, 549);
    add_reading(2, 100);    // between windows
    add_reading(3, 99);
    add_reading(3, 549);
    add_reading(3, 1023);
    add_reading(2, 1023);
    wait_idle();
    run_random(160, 1'b1);
    wait_idle();

    // Full-range window shadows the rest; single points at both ends; an empty one.
    set_window(0, 0, 1023);
    set_window(1, 0, 0);
    set_window(2, 1023, 1023);
    set_window(3, 1023, 0);
    run_random(30, 1'b1);
    wait_idle();
    set_window(0, 1023, 0);
    run_random(30, 1'b1);
    wait_idle();

    repeat (2) begin
      for (int c = 0; c < KEY_COLS; c++) begin
        int a;
        int b;
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
        if ($urandom_range(0, 9) < 7 && a > b) set_window(c, b, a);
        else set_window(c, a, b);
      end
      run_random(75, 1'b1);
      wait_idle();
    end

    for (int c = 0; c < KEY_COLS; c++) begin
      int p;
      p = $urandom_range(0, 1023);
      set_window(c, p, p);
    end
    run_random(60, 1'b1);
    wait_idle();

    set_ladder();
    run_random(90, 1'b0);
    wait_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
